/* src/sp3hb_pkg.sv */
// Shared types, constants and scale-table functions of the sp3 hopping block.
package sp3hb_pkg;

    // Fixed-point constants of the distance scaling.
    localparam int R1_Q13 = 20070;
    localparam longint unsigned RECIP_Q40 = 64'd54783837;
    localparam longint unsigned A_Q16 = 64'd190011;
    localparam longint unsigned BMAG_Q32 = 64'd54202916;
    localparam longint signed CS3_Q30 = 380413235;
    localparam longint signed CS2_Q30 = 207486140;
    localparam longint signed CS1_Q30 = -87923735;
    localparam longint signed CS0_Q30 = 7236227;
    localparam logic [23:0] FMAX = 24'hFFFFFF;
    localparam int DEFAULT_SCALE_TABLE_DEPTH = 256;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HOP_SS_SIGMA = 3'd0;
    localparam logic [2:0] CFG_HOP_SP_SIGMA = 3'd1;
    localparam logic [2:0] CFG_HOP_PP_SIGMA = 3'd2;
    localparam logic [2:0] CFG_HOP_PP_PI = 3'd3;
    localparam logic [2:0] CFG_CUTOFF_DISTANCE = 3'd4;

    // Register reset values.
    localparam logic signed [23:0] RST_HOP_SS_SIGMA = -24'sd327680;
    localparam logic signed [23:0] RST_HOP_SP_SIGMA = 24'sd308019;
    localparam logic signed [23:0] RST_HOP_PP_SIGMA = 24'sd360448;
    localparam logic signed [23:0] RST_HOP_PP_PI = -24'sd101581;
    localparam logic [15:0] RST_CUTOFF_DISTANCE = 16'd21299;

    // One input word: an atom pair.
    typedef struct packed {
        logic [9:0]         atom_a;
        logic [9:0]         atom_b;
        logic [15:0]        distance;
        logic signed [15:0] cos_x;
        logic signed [15:0] cos_y;
        logic signed [15:0] cos_z;
    } t_pair;

    // One result word: a hopping matrix element.
    typedef struct packed {
        logic [11:0]        row;
        logic [11:0]        col;
        logic signed [23:0] value;
        logic               last;
    } t_result;

    // Configuration register contents.
    typedef struct packed {
        logic signed [23:0] hop_ss_sigma;
        logic signed [23:0] hop_sp_sigma;
        logic signed [23:0] hop_pp_sigma;
        logic signed [23:0] hop_pp_pi;
        logic [15:0]        cutoff_distance;
    } t_cfg;

    // One classified pair with its scaled hopping constants.
    typedef struct packed {
        logic [9:0]         atom_a;
        logic [9:0]         atom_b;
        logic signed [15:0] cos_x;
        logic signed [15:0] cos_y;
        logic signed [15:0] cos_z;
        logic signed [32:0] vss;
        logic signed [32:0] vsp;
        logic signed [32:0] vppp;
        logic signed [33:0] diff;
    } t_job;

    // Unsigned shift-and-subtract division, used at elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Integer square root, bit by bit.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v = v_in;
        r = '0;
        bt = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bt > v) bt = bt >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (bt != 0) begin
                if (v >= r + bt) begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
        end
        return r;
    endfunction

    // Distance of table point i, Q16.
    function automatic logic [63:0] rom_point(input int i, input int depth);
        return udiv64(64'(i) * 64'(R1_Q13) * 64'd8, 64'(depth - 1));
    endfunction

    // Scale factor A*exp(B*d^6.5)/d^2 at distance dq (Q16), result Q8.16.
    function automatic logic [23:0] rom_entry(input logic [63:0] dq);
        logic [63:0] d2, d4, d6, s, d65, a, y, y2h, e, f;
        d2 = (dq * dq) >> 16;
        if (d2 == 0) return FMAX;
        d4 = (d2 * d2) >> 16;
        d6 = (d4 * d2) >> 16;
        s = isqrt64(dq << 16);
        d65 = (d6 * s) >> 16;
        a = (d65 * BMAG_Q32) >> 32;
        y = a << 6;
        y2h = (y * y) >> 31;
        e = (64'd1 << 30) - y + y2h - udiv64(y2h * y, 64'd3 << 30);
        for (int k = 0; k < 8; k++) e = (e * e) >> 30;
        f = udiv64(A_Q16 * e, d2 << 14);
        return (f > 64'(FMAX)) ? FMAX : f[23:0];
    endfunction

endpackage

/* src/sp3hb_front.sv */
// Front end: accepts a pair, computes the distance factor and the scaled constants.
module sp3hb_front
    import sp3hb_pkg::*;
#(
    parameter int SCALE_TABLE_DEPTH = DEFAULT_SCALE_TABLE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_pair i_pair,
    input  t_cfg  i_cfg,
    output logic  o_push,
    output t_job  o_job,
    input  logic  i_full
);

    localparam int KW = $clog2(SCALE_TABLE_DEPTH);
    localparam int PW = 15 + KW;
    localparam logic [KW-1:0] K_LAST = KW'(SCALE_TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        F_IDLE, F_PREP, F_KMUL, F_KFIX, F_ROM, F_NSUM, F_QMUL, F_QSUM, F_QFIX,
        F_SPL, F_SFIN, F_SCALE, F_PUSH
    } t_fstate;

    t_fstate r_state;
    t_pair   r_pair;
    logic [PW-1:0]      r_p;
    logic [PW+25:0]     r_prod;
    logic [KW-1:0]      r_k;
    logic [14:0]        r_r;
    logic [38:0]        r_t0, r_t1, r_num;
    logic [44:0]        r_pa;
    logic [45:0]        r_pb;
    logic [24:0]        r_q0;
    logic [23:0]        r_f;
    logic [15:0]        r_u;
    logic signed [39:0] r_acc;
    logic [1:0]         r_step;
    logic signed [32:0] r_v [4];

    // Scale table, built at elaboration.
    logic [23:0] rom_w [SCALE_TABLE_DEPTH];
    for (genvar gi = 0; gi < SCALE_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [23:0] ROM_VAL = rom_entry(rom_point(gi, SCALE_TABLE_DEPTH));
        assign rom_w[gi] = ROM_VAL;
    end

    // Datapath of the sequencer steps.
    logic [KW-1:0]      k0, k_next;
    logic [PW-1:0]      r0;
    logic [64:0]        qsum;
    logic [38:0]        rq;
    logic signed [56:0] spl_prod;
    logic signed [39:0] coef;
    logic signed [25:0] spl_sh;
    logic signed [23:0] hop_sel;
    logic signed [24:0] f_s;
    logic signed [48:0] sc_prod;

    always_comb begin
        k0 = r_prod[40 +: KW];
        r0 = r_p - PW'(PW'(k0) * PW'(R1_Q13));
        k_next = r_k + 1'b1;
        qsum = {r_pa, 20'd0} + 65'(r_pb);
        rq = r_num - 39'(39'(r_q0) * 39'(R1_Q13));
        spl_prod = r_acc * $signed({1'b0, r_u});
        case (r_step)
            2'd0:    coef = 40'(CS2_Q30);
            2'd1:    coef = 40'(CS1_Q30);
            default: coef = 40'(CS0_Q30);
        endcase
        spl_sh = 26'(r_acc >>> 14);
        case (r_step)
            2'd0:    hop_sel = i_cfg.hop_ss_sigma;
            2'd1:    hop_sel = i_cfg.hop_sp_sigma;
            2'd2:    hop_sel = i_cfg.hop_pp_sigma;
            default: hop_sel = i_cfg.hop_pp_pi;
        endcase
        f_s = $signed({1'b0, r_f});
        sc_prod = hop_sel * f_s;
    end

    // Sequencer and its registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (start) begin
                        r_pair <= i_pair;
                        r_state <= F_PREP;
                    end
                end
                F_PREP: begin
                    r_step <= 2'd0;
                    if (r_pair.distance > i_cfg.cutoff_distance) begin
                        r_f <= '0;
                        r_state <= F_SCALE;
                    end else if (r_pair.distance <= 16'(R1_Q13)) begin
                        r_p <= PW'(r_pair.distance[14:0]) * PW'(K_LAST);
                        r_state <= F_KMUL;
                    end else begin
                        r_u <= r_pair.distance - 16'(R1_Q13);
                        r_acc <= 40'(CS3_Q30);
                        r_state <= F_SPL;
                    end
                end
                F_KMUL: begin
                    r_prod <= (PW+26)'(r_p) * (PW+26)'(RECIP_Q40);
                    r_state <= F_KFIX;
                end
                F_KFIX: begin
                    if (r0 >= PW'(R1_Q13)) begin
                        r_k <= k0 + 1'b1;
                        r_r <= 15'(r0 - PW'(R1_Q13));
                    end else begin
                        r_k <= k0;
                        r_r <= 15'(r0);
                    end
                    r_state <= F_ROM;
                end
                F_ROM: begin
                    if (r_k == K_LAST) begin
                        r_f <= rom_w[K_LAST];
                        r_state <= F_SCALE;
                    end else begin
                        r_t0 <= 39'(rom_w[r_k]) * 39'(15'(R1_Q13) - r_r);
                        r_t1 <= 39'(rom_w[k_next]) * 39'(r_r);
                        r_state <= F_NSUM;
                    end
                end
                F_NSUM: begin
                    r_num <= r_t0 + r_t1;
                    r_state <= F_QMUL;
                end
                F_QMUL: begin
                    r_pa <= 45'(r_num[38:20]) * 45'(RECIP_Q40);
                    r_pb <= 46'(r_num[19:0]) * 46'(RECIP_Q40);
                    r_state <= F_QSUM;
                end
                F_QSUM: begin
                    r_q0 <= qsum[64:40];
                    r_state <= F_QFIX;
                end
                F_QFIX: begin
                    r_f <= (rq >= 39'(R1_Q13)) ? 24'(r_q0 + 1'b1) : 24'(r_q0);
                    r_state <= F_SCALE;
                end
                F_SPL: begin
                    r_acc <= 40'(spl_prod >>> 13) + coef;
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd2) r_state <= F_SFIN;
                end
                F_SFIN: begin
                    if (spl_sh < 0) r_f <= '0;
                    else if (spl_sh > 26'sh0FFFFFF) r_f <= FMAX;
                    else r_f <= spl_sh[23:0];
                    r_step <= 2'd0;
                    r_state <= F_SCALE;
                end
                F_SCALE: begin
                    r_v[r_step] <= 33'(sc_prod >>> 16);
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Queue word and handshake.
    assign busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_full;
    always_comb begin
        o_job.atom_a = r_pair.atom_a;
        o_job.atom_b = r_pair.atom_b;
        o_job.cos_x = r_pair.cos_x;
        o_job.cos_y = r_pair.cos_y;
        o_job.cos_z = r_pair.cos_z;
        o_job.vss = r_v[0];
        o_job.vsp = r_v[1];
        o_job.vppp = r_v[3];
        o_job.diff = 34'(r_v[2]) - 34'(r_v[3]);
    end

    // An accepted word always starts the classification step.
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == F_PREP))
        else $error("front did not start on an accepted word");

endmodule

/* src/sp3hb_queue.sv */
// Short queue between the front end and the element generator.
module sp3hb_queue
    import sp3hb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    assign o_job = r_mem[r_rd_ptr];
    assign o_full = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(QUEUE_DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

endmodule

/* src/sp3hb_back.sv */
// Back end: expands one queued pair into its 16 hopping elements, one per cycle.
module sp3hb_back
    import sp3hb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_job,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_strobe,
    output t_result o_result
);

    t_job        r_job;
    logic        r_active;
    logic [3:0]  r_n;

    logic               r_s1_valid;
    logic [3:0]         r_s1_n;
    logic [9:0]         r_s1_a, r_s1_b;
    logic signed [31:0] r_s1_cc;
    logic signed [48:0] r_s1_psp;
    logic signed [32:0] r_s1_vss, r_s1_vppp;
    logic signed [33:0] r_s1_diff;

    logic               r_s2_valid;
    logic [3:0]         r_s2_n;
    logic [9:0]         r_s2_a, r_s2_b;
    logic signed [35:0] r_s2_pp;
    logic signed [34:0] r_s2_sp;
    logic signed [32:0] r_s2_vss, r_s2_vppp;

    // Saturate to the 24-bit result range.
    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        if (v > 40'sd8388607) return 24'sh7FFFFF;
        if (v < -40'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    // Element selection and first products.
    logic [1:0]         ei, ej;
    logic signed [15:0] c_arr [4];
    logic signed [15:0] ci, cj, csel;
    logic signed [31:0] s1_cc;
    logic signed [48:0] s1_psp;

    always_comb begin
        ei = r_n[3:2];
        ej = r_n[1:0];
        c_arr[0] = '0;
        c_arr[1] = r_job.cos_x;
        c_arr[2] = r_job.cos_y;
        c_arr[3] = r_job.cos_z;
        ci = c_arr[ei];
        cj = c_arr[ej];
        csel = (ei == 2'd0) ? cj : ci;
        s1_cc = ci * cj;
        s1_psp = csel * r_job.vsp;
    end

    // Second products.
    logic signed [65:0] pm_full;
    logic signed [63:0] pm;
    assign pm_full = r_s1_cc * r_s1_diff;
    assign pm = pm_full[63:0];

    // Final value.
    logic [1:0]         oi, oj;
    logic signed [39:0] val;
    always_comb begin
        oi = r_s2_n[3:2];
        oj = r_s2_n[1:0];
        if (oi == 2'd0 && oj == 2'd0) val = 40'(r_s2_vss);
        else if (oi == 2'd0) val = 40'(r_s2_sp);
        else if (oj == 2'd0) val = -40'(r_s2_sp);
        else val = 40'(r_s2_pp) + ((oi == oj) ? 40'(r_s2_vppp) : 40'sd0);
    end

    assign o_pop = !i_empty && (!r_active || r_n == 4'd15);

    // Element counter and pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_n <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_n <= '0;
            end else if (r_active) begin
                r_n <= r_n + 1'b1;
                if (r_n == 4'd15) r_active <= 1'b0;
            end
            r_s1_valid <= r_active;
            r_s2_valid <= r_s1_valid;
            o_strobe <= r_s2_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        r_s1_n <= r_n;
        r_s1_a <= r_job.atom_a;
        r_s1_b <= r_job.atom_b;
        r_s1_cc <= s1_cc;
        r_s1_psp <= s1_psp;
        r_s1_vss <= r_job.vss;
        r_s1_vppp <= r_job.vppp;
        r_s1_diff <= r_job.diff;
        r_s2_n <= r_s1_n;
        r_s2_a <= r_s1_a;
        r_s2_b <= r_s1_b;
        r_s2_pp <= pm[63:28];
        r_s2_sp <= 35'(r_s1_psp >>> 14);
        r_s2_vss <= r_s1_vss;
        r_s2_vppp <= r_s1_vppp;
        o_result.row <= {r_s2_a, oi};
        o_result.col <= {r_s2_b, oj};
        o_result.value <= sat24(val);
        o_result.last <= (r_s2_n == 4'd15);
    end

    // A block, once begun, runs to its sixteenth element.
    a_block_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_n != 4'd15) |=> (r_active && r_n == $past(r_n) + 4'd1))
        else $error("element block broken off");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_n == 4'd15) |=> (o_strobe && o_result.last))
        else $error("last element not marked");

endmodule

/* src/sp3_hopping_block.sv */
// Top level of the sp3 Slater-Koster hopping block generator.
//
// Each accepted pair yields 16 words on o_result, row orbital s,x,y,z outer and column
// orbital inner, each shown for one cycle with o_strobe; the receiver cannot stall, so
// every word must be taken when it appears. The front end takes no new pair until its
// sequencer has pushed the current one into the queue; the table path, with its two
// reciprocal divisions by the table edge distance, is its longest path. A two-entry
// queue feeds the element generator, which emits one word per cycle while it has a
// pair; the sustained rate is therefore set by the single-word result port. After a
// pair leaves the queue, its words pass through the job register, the s1 and s2
// pipeline registers and the output register. The scale table is a constant built at
// elaboration, so no clearing pass follows reset. Configuration writes take effect at
// once and must occur only while the block is idle.
module sp3_hopping_block
    import sp3hb_pkg::*;
#(
    parameter int SCALE_TABLE_DEPTH = DEFAULT_SCALE_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_pair       i_pair,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_push, q_full, q_pop, q_empty;
    t_job push_job, pop_job;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hop_ss_sigma <= RST_HOP_SS_SIGMA;
            r_cfg.hop_sp_sigma <= RST_HOP_SP_SIGMA;
            r_cfg.hop_pp_sigma <= RST_HOP_PP_SIGMA;
            r_cfg.hop_pp_pi <= RST_HOP_PP_PI;
            r_cfg.cutoff_distance <= RST_CUTOFF_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOP_SS_SIGMA:    r_cfg.hop_ss_sigma <= i_cfg_data;
                CFG_HOP_SP_SIGMA:    r_cfg.hop_sp_sigma <= i_cfg_data;
                CFG_HOP_PP_SIGMA:    r_cfg.hop_pp_sigma <= i_cfg_data;
                CFG_HOP_PP_PI:       r_cfg.hop_pp_pi <= i_cfg_data;
                CFG_CUTOFF_DISTANCE: r_cfg.cutoff_distance <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    sp3hb_front #(
        .SCALE_TABLE_DEPTH(SCALE_TABLE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_pair  (i_pair),
        .i_cfg   (r_cfg),
        .o_push  (q_push),
        .o_job   (push_job),
        .i_full  (q_full)
    );

    sp3hb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (pop_job),
        .o_empty (q_empty)
    );

    sp3hb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (pop_job),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the sp3 hopping block: predicted versus actual words.
module tb;
    import sp3hb_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_EDGE = 20070;
    localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 30;

    // Predicts the 16 hopping words of each pair and checks them in order.
    class hop_scoreboard;
        logic signed [23:0] hop_k [4];
        logic [15:0]        cutoff;
        logic [23:0]        scale_rom [TABLE_DEPTH];
        t_result            pending_words [$];
        int                 errors;

        function new();
            hop_k[0] = RST_HOP_SS_SIGMA;
            hop_k[1] = RST_HOP_SP_SIGMA;
            hop_k[2] = RST_HOP_PP_SIGMA;
            hop_k[3] = RST_HOP_PP_PI;
            cutoff = RST_CUTOFF_DISTANCE;
            errors = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                scale_rom[i] = table_value(64'(i) * 64'(TABLE_EDGE) * 8 / (TABLE_DEPTH - 1));
        endfunction

        function logic [63:0] root(input logic [63:0] v_in);
            logic [63:0] v, r, bt;
            v = v_in;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > v) bt = bt >> 2;
            while (bt != 0) begin
                if (v >= r + bt) begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
            return r;
        endfunction

        // Decaying factor at table distance dq (Q16), saturated near zero.
        function logic [23:0] table_value(input logic [63:0] dq);
            logic [63:0] d2, d4, d6, s, d65, a, y, y2h, e, f;
            d2 = (dq * dq) >> 16;
            if (d2 == 0) return 24'hFFFFFF;
            d4 = (d2 * d2) >> 16;
            d6 = (d4 * d2) >> 16;
            s = root(dq << 16);
            d65 = (d6 * s) >> 16;
            a = (d65 * 64'd54202916) >> 32;
            y = a << 6;
            y2h = (y * y) >> 31;
            e = (64'd1 << 30) - y + y2h - (y2h * y) / (64'd3 << 30);
            for (int k = 0; k < 8; k++) e = (e * e) >> 30;
            f = (64'd190011 * e) / (d2 << 14);
            return (f > 64'hFFFFFF) ? 24'hFFFFFF : f[23:0];
        endfunction

        function longint distance_factor(input logic [15:0] x);
            longint p, k, r, t, acc;
            if (x > cutoff) return 0;
            if (x <= TABLE_EDGE) begin
                p = longint'(x) * (TABLE_DEPTH - 1);
                k = p / TABLE_EDGE;
                r = p % TABLE_EDGE;
                if (k >= TABLE_DEPTH - 1) return scale_rom[TABLE_DEPTH - 1];
                return (longint'(scale_rom[k]) * (TABLE_EDGE - r)
                        + longint'(scale_rom[k + 1]) * r) / TABLE_EDGE;
            end
            // Cubic spline past the table, Horner form in Q30.
            t = (longint'(x) - TABLE_EDGE) <<< 11;
            acc = 380413235;
            acc = ((acc * t) >>> 24) + 207486140;
            acc = ((acc * t) >>> 24) - 87923735;
            acc = ((acc * t) >>> 24) + 7236227;
            acc = acc >>> 14;
            if (acc < 0) return 0;
            if (acc > 64'hFFFFFF) return 64'hFFFFFF;
            return acc;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [23:0] data);
            if (idx < CFG_CUTOFF_DISTANCE) hop_k[idx] = data;
            else if (idx == CFG_CUTOFF_DISTANCE) cutoff = data[15:0];
        endfunction

        function void note_pair(input t_pair p);
            longint f, v, vsp, vpps, vppp, diff;
            longint c [4];
            t_result w;
            f = distance_factor(p.distance);
            c[0] = 0;
            c[1] = p.cos_x;
            c[2] = p.cos_y;
            c[3] = p.cos_z;
            vsp = (longint'(hop_k[1]) * f) >>> 16;
            vpps = (longint'(hop_k[2]) * f) >>> 16;
            vppp = (longint'(hop_k[3]) * f) >>> 16;
            diff = vpps - vppp;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    if (i == 0 && j == 0) v = (longint'(hop_k[0]) * f) >>> 16;
                    else if (i == 0) v = (c[j] * vsp) >>> 14;
                    else if (j == 0) v = -((c[i] * vsp) >>> 14);
                    else v = ((c[i] * c[j] * diff) >>> 28) + ((i == j) ? vppp : 0);
                    if (v > 8388607) v = 8388607;
                    if (v < -8388608) v = -8388608;
                    w.row = 12'(4 * p.atom_a + i);
                    w.col = 12'(4 * p.atom_b + j);
                    w.value = v[23:0];
                    w.last = (i == 3 && j == 3);
                    pending_words.push_back(w);
                end
            end
        endfunction

        function void check_word(input t_result got);
            t_result exp_w;
            if (pending_words.size() == 0) begin
                $error("unexpected word row=%0d col=%0d", got.row, got.col);
                errors++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.row !== exp_w.row) begin
                $error("row: expected %0d, got %0d", exp_w.row, got.row);
                errors++;
            end
            if (got.col !== exp_w.col) begin
                $error("col: expected %0d, got %0d", exp_w.col, got.col);
                errors++;
            end
            if (got.value !== exp_w.value) begin
                $error("value: expected %0d, got %0d", exp_w.value, got.value);
                errors++;
            end
            if (got.last !== exp_w.last) begin
                $error("last: expected %0d, got %0d", exp_w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_pair       i_pair = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_HOP_SS_SIGMA;
    logic [23:0] i_cfg_data = '0;

    hop_scoreboard sb = new();
    int idle_cycles = 0;

    sp3_hopping_block u_top (.*);

    always #2 i_clk = ~i_clk;

    // Every result word is taken in the cycle it appears.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_word(o_result);
    end

    // Watchdog on cycles without any accepted word in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Holds start until the pair is taken; start stays high for a following pair.
    task automatic send_pair(input t_pair p);
        start <= 1'b1;
        i_pair <= p;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_pair(p);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted word has arrived and the block has gone quiet.
    task automatic drain();
        pause(1);
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write, with the write enable dropped low again before the task returns.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [23:0] ss, input logic [23:0] sp,
                             input logic [23:0] pps, input logic [23:0] ppp,
                             input logic [15:0] cut);
        write_reg(CFG_HOP_SS_SIGMA, ss);
        write_reg(CFG_HOP_SP_SIGMA, sp);
        write_reg(CFG_HOP_PP_SIGMA, pps);
        write_reg(CFG_HOP_PP_PI, ppp);
        write_reg(CFG_CUTOFF_DISTANCE, {8'h00, cut});
    endtask

    function automatic logic [15:0] pick_distance();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, TABLE_EDGE));
            4, 5:       return 16'($urandom_range(TABLE_EDGE + 1, 23500));
            6:          return 16'($urandom_range(0, 300));
            7:          return 16'($urandom);
            8: begin
                case ($urandom_range(0, 5))
                    0: return 16'd0;
                    1: return 16'(TABLE_EDGE);
                    2: return 16'(TABLE_EDGE + 1);
                    3: return sb.cutoff;
                    4: return sb.cutoff + 16'd1;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(16000, 24000));
        endcase
    endfunction

    // Cosines mostly in the unit range, sometimes any 16-bit value.
    function automatic logic signed [15:0] pick_cos();
        if ($urandom_range(0, 5) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        p.atom_a = 10'($urandom);
        p.atom_b = ($urandom_range(0, 7) == 0) ? p.atom_a : 10'($urandom);
        p.distance = pick_distance();
        p.cos_x = pick_cos();
        p.cos_y = pick_cos();
        p.cos_z = pick_cos();
        return p;
    endfunction

    // Bursts of random length with random gaps, and some long unbroken stretches.
    task automatic random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_pair(random_pair());
                sent++;
            end
            pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
        end
    endtask

    function automatic t_pair make_pair(input logic [9:0] a, input logic [9:0] b,
                                        input logic [15:0] d, input logic [15:0] cx,
                                        input logic [15:0] cy, input logic [15:0] cz);
        t_pair p;
        p.atom_a = a;
        p.atom_b = b;
        p.distance = d;
        p.cos_x = cx;
        p.cos_y = cy;
        p.cos_z = cz;
        return p;
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs with the reset constants.
        send_pair(make_pair(10'd0, 10'd1023, 16'd0, 16'h4000, 16'h0000, 16'h0000));
        send_pair(make_pair(10'd1023, 10'd1023, 16'd1, 16'hC000, 16'h4000, 16'hC000));
        send_pair(make_pair(10'd5, 10'd6, 16'd20070, 16'h2D41, 16'h2D41, 16'h0000));
        send_pair(make_pair(10'd7, 10'd8, 16'd20071, 16'h24F3, 16'hDB0D, 16'h24F3));
        pause(5);
        send_pair(make_pair(10'd9, 10'd3, 16'd21299, 16'h8000, 16'h7FFF, 16'h8000));
        send_pair(make_pair(10'd511, 10'd512, 16'd21300, 16'h4000, 16'h4000, 16'h4000));
        send_pair(make_pair(10'd100, 10'd200, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_pair(make_pair(10'd682, 10'd341, 16'd10000, 16'h0000, 16'h0000, 16'h4000));
        send_pair(make_pair(10'd341, 10'd682, 16'd5000, 16'h8000, 16'h8000, 16'h8000));
        drain();

        random_phase(70);
        drain();

        // Extreme constants, pp_pi at the negative end, and the widest cutoff.
        write_all(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'hFFFF);
        send_pair(make_pair(10'd1, 10'd2, 16'd0, 16'h8000, 16'h8000, 16'h7FFF));
        send_pair(make_pair(10'd3, 10'd4, 16'hFFFF, 16'h4000, 16'hC000, 16'h4000));
        random_phase(70);
        drain();

        // Extreme constants with the signs swapped and a zero cutoff: only distance zero passes.
        write_all(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 16'h0000);
        send_pair(make_pair(10'd1, 10'd1, 16'd0, 16'h8000, 16'h7FFF, 16'h8000));
        send_pair(make_pair(10'd2, 10'd1, 16'd1, 16'h4000, 16'h4000, 16'h4000));
        random_phase(60);
        drain();

        // Cutoff inside the table range.
        write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 16'd15000);
        random_phase(70);
        drain();

        // Random constants; writes to unused indexes must change nothing.
        write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom_range(20000, 30000)));
        for (int idx = CFG_FIRST_UNUSED; idx <= 7; idx++) write_reg(3'(idx), 24'($urandom));
        random_phase(80);
        drain();

        // Back to the reset constants.
        write_all(RST_HOP_SS_SIGMA, RST_HOP_SP_SIGMA, RST_HOP_PP_SIGMA, RST_HOP_PP_PI,
                  RST_CUTOFF_DISTANCE);
        random_phase(90);
        drain();

        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            if (sb.pending_words.size() != 0)
                $error("%0d predicted words never arrived", sb.pending_words.size());
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
